/* hw/rtl/bffa_pkg.sv */
// Shared constants for the bitmap first-fit block allocator.
// Operation and status codes plus parameter defaults; no dependencies.
`default_nettype none

package bffa_pkg;

  // Defaults for the top-level parameters. WORD_BITS must be a power of two.
  localparam int MAP_BITS_DEF    = 8192;
  localparam int WORD_BITS_DEF   = 32;
  localparam int MAX_REQUEST_DEF = 8;

  // Fixed field widths of the command and result beats
  localparam int FUNC_W   = 3;
  localparam int TARGET_W = 13;
  localparam int COUNT_W  = 4;
  localparam int NUMBLK_W = 14;
  localparam int STATUS_W = 2;

  localparam int NUMBLK_RESET = 8192;

  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MARK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FREE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/bffa_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Uses bffa_pkg for default sizes only.
`default_nettype none

module bffa_ram #(
  parameter int WIDTH = bffa_pkg::WORD_BITS_DEF,
  parameter int DEPTH = bffa_pkg::MAP_BITS_DEF / bffa_pkg::WORD_BITS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bffa_find.sv */
// Shared search unit: lowest free bit of one bitmap word inside a bit window.
// Depends on bffa_pkg for the default word width.
`default_nettype none

module bffa_find #(
  parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF,
  localparam int BO_W = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [BO_W-1:0]      lo,     // first bit to consider
  input  wire logic [BO_W:0]        hi,     // bits at or above this are past the limit
  output logic                      found,
  output logic      [BO_W-1:0]      pos
);

  import bffa_pkg::*;

  logic [WORD_BITS-1:0] cand;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      cand[i] = !word[i] && (i >= 32'(lo)) && (i < 32'(hi));
    end
  end

  // Scan from the top so the lowest candidate wins
  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = BO_W'(i);
      end
    end
  end

  assign found = |cand;

endmodule

`default_nettype wire

/* hw/rtl/bitmap_first_fit_block_allocator.sv */
// Top level of the bitmap first-fit block allocator: command sequencer.
// Depends on bffa_pkg, bffa_ram (usage bitmap) and bffa_find (word search).
`default_nettype none

// A command beat is taken when start is high and busy is low. Each result is
// strobed by result_valid for one cycle and cannot be held off, so the user
// must take it as it comes. After reset the bitmap is swept to zero, one word
// a cycle, over all MAP_WORDS words (256 by default) with busy high; the
// block-count register can be written meanwhile. A clear runs that same sweep
// and then gives its result. Mark, free and query go through a word read, an
// update and a result. An index out of range, or an unknown operation,
// answers in the cycle after the command and leaves busy low. An allocate
// reads and searches each bitmap word the search touches, one search per
// granted block, with one WORD_BITS-bit word examined per search, bound by
// the single read port and the single search unit. Slots that find the map
// full come out one per cycle.
module bitmap_first_fit_block_allocator #(
  parameter int MAP_BITS    = bffa_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF,
  parameter int MAX_REQUEST = bffa_pkg::MAX_REQUEST_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bffa_pkg::FUNC_W-1:0]   func,
  input  wire logic [bffa_pkg::TARGET_W-1:0] target_block,
  input  wire logic [bffa_pkg::COUNT_W-1:0]  request_count,
  input  wire logic                          cfg_we,
  input  wire logic [bffa_pkg::NUMBLK_W-1:0] cfg_wdata,
  output logic                               result_valid,
  output logic      [bffa_pkg::TARGET_W-1:0] block_index,
  output logic      [bffa_pkg::STATUS_W-1:0] status,
  output logic                               was_used,
  output logic                               last
);

  import bffa_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BO_W      = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(MAP_BITS) + 1;
  localparam int RC_W      = $clog2(MAX_REQUEST + 1);
  localparam int LIM_RESET = (NUMBLK_RESET > MAP_BITS) ? MAP_BITS : NUMBLK_RESET;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_EVAL,
    S_FULL,
    S_IDX_RD,
    S_IDX_EVAL
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    limit;
  logic [IDX_W-1:0]    scan;
  logic [RC_W-1:0]     cnt;
  logic [TARGET_W-1:0] tgt;
  logic [FUNC_W-1:0]   op;
  logic [WA_W-1:0]     clr_addr;
  logic                clr_reply;

  logic                 ram_we;
  logic [WA_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [IDX_W-1:0]     tgt_idx;
  logic [WA_W-1:0]      tgt_word;
  logic [BO_W-1:0]      tgt_off;
  logic [WA_W-1:0]      scan_word;
  logic [BO_W-1:0]      scan_off;
  logic [IDX_W-1:0]     word_base;
  logic [IDX_W-1:0]     rem;
  logic [BO_W:0]        hi;
  logic                 found;
  logic [BO_W-1:0]      pos;
  logic [IDX_W-1:0]     hit_idx;
  logic [RC_W-1:0]      req_sat;
  logic                 in_range;
  logic                 accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign tgt_idx   = IDX_W'(tgt);
  assign tgt_word  = tgt_idx[BO_W +: WA_W];
  assign tgt_off   = tgt_idx[BO_W-1:0];
  assign scan_word = scan[BO_W +: WA_W];
  assign scan_off  = scan[BO_W-1:0];
  assign word_base = {scan[IDX_W-1:BO_W], {BO_W{1'b0}}};
  assign rem       = limit - word_base;
  assign hi        = (rem >= IDX_W'(WORD_BITS)) ? (BO_W+1)'(WORD_BITS) : rem[BO_W:0];
  assign hit_idx   = {scan[IDX_W-1:BO_W], pos};
  assign req_sat   = (32'(request_count) > MAX_REQUEST) ? RC_W'(MAX_REQUEST)
                                                        : RC_W'(request_count);
  assign in_range  = 32'(target_block) < 32'(limit);

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bffa_find #(
    .WORD_BITS (WORD_BITS)
  ) u_find (
    .word  (ram_rdata),
    .lo    (scan_off),
    .hi    (hi),
    .found (found),
    .pos   (pos)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_word;
    ram_wdata = ram_rdata | (WORD_BITS'(1) << pos);
    ram_raddr = (state == S_IDX_RD) ? tgt_word : scan_word;
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_ALLOC_EVAL: begin
        ram_we = found;
      end
      S_IDX_EVAL: begin
        ram_waddr = tgt_word;
        ram_we    = (op == FN_MARK) || (op == FN_FREE);
        ram_wdata = (op == FN_MARK) ? (ram_rdata | (WORD_BITS'(1) << tgt_off))
                                    : (ram_rdata & ~(WORD_BITS'(1) << tgt_off));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      clr_reply    <= 1'b0;
      limit        <= IDX_W'(LIM_RESET);
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        limit <= (32'(cfg_wdata) > MAP_BITS) ? IDX_W'(MAP_BITS) : IDX_W'(cfg_wdata);
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WA_W'(MAP_WORDS - 1)) begin
            state    <= S_IDLE;
            clr_addr <= '0;
            if (clr_reply) begin
              result_valid <= 1'b1;
              block_index  <= tgt;
              status       <= ST_OK;
              was_used     <= 1'b0;
              last         <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            tgt <= target_block;
            op  <= func;
            priority if (func == FN_CLEAR) begin
              state     <= S_CLR;
              clr_reply <= 1'b1;
            end else if (func == FN_ALLOC) begin
              cnt  <= req_sat;
              scan <= '0;
              // zero count: nothing granted, nothing reported
              if (req_sat != '0) begin
                state <= S_ALLOC_RD;
              end
            end else if ((func == FN_MARK || func == FN_FREE || func == FN_QUERY)
                         && in_range) begin
              state <= S_IDX_RD;
            end else begin
              result_valid <= 1'b1;
              block_index  <= target_block;
              status       <= ST_RANGE;
              was_used     <= 1'b0;
              last         <= 1'b1;
            end
          end
        end
        S_ALLOC_RD: begin
          state <= (scan >= limit) ? S_FULL : S_ALLOC_EVAL;
        end
        S_ALLOC_EVAL: begin
          if (found) begin
            result_valid <= 1'b1;
            block_index  <= TARGET_W'(hit_idx);
            status       <= ST_OK;
            was_used     <= 1'b0;
            last         <= (cnt == RC_W'(1));
            cnt          <= cnt - 1'b1;
            scan         <= hit_idx + 1'b1;
            state        <= (cnt == RC_W'(1)) ? S_IDLE : S_ALLOC_RD;
          end else begin
            // advance to the next word
            scan  <= word_base + IDX_W'(WORD_BITS);
            state <= S_ALLOC_RD;
          end
        end
        S_FULL: begin
          result_valid <= 1'b1;
          block_index  <= '0;
          status       <= ST_FULL;
          was_used     <= 1'b0;
          last         <= (cnt == RC_W'(1));
          cnt          <= cnt - 1'b1;
          if (cnt == RC_W'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDX_RD: begin
          state <= S_IDX_EVAL;
        end
        S_IDX_EVAL: begin
          result_valid <= 1'b1;
          block_index  <= tgt;
          status       <= ST_OK;
          was_used     <= ram_rdata[tgt_off];
          last         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A granted block always lies below the block limit
  a_grant_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_EVAL && found) |-> (hit_idx < limit))
    else $error("granted block beyond limit");

  // More beats of the same command still to come keep the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("non-final result while idle");

  // The bitmap is never written while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("bitmap write while idle");

  // A clear command starts the sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FN_CLEAR) |=> (busy && state == S_CLR))
    else $error("clear did not start sweep");

endmodule

`default_nettype wire

/* bench/bffa_checker.sv */
// Scoreboard for the bitmap first-fit block allocator: watches command, config
// and result beats, predicts each result beat and compares it field by field.
// Depends on bffa_pkg for field widths, operation and status codes.
`timescale 1ns / 1ps

module bffa_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [bffa_pkg::FUNC_W-1:0]   func,
  input  wire logic [bffa_pkg::TARGET_W-1:0] target_block,
  input  wire logic [bffa_pkg::COUNT_W-1:0]  request_count,
  input  wire logic                          cfg_we,
  input  wire logic [bffa_pkg::NUMBLK_W-1:0] cfg_wdata,
  input  wire logic                          result_valid,
  input  wire logic [bffa_pkg::TARGET_W-1:0] block_index,
  input  wire logic [bffa_pkg::STATUS_W-1:0] status,
  input  wire logic                          was_used,
  input  wire logic                          last,
  output int unsigned                        fail_count,
  output int unsigned                        owed_count,
  output int unsigned                        cmd_count,
  output int unsigned                        beat_count,
  output int unsigned                        grant_count,
  output int unsigned                        full_count,
  output int unsigned                        range_count
);

  import bffa_pkg::*;

  localparam int MAP_BITS    = MAP_BITS_DEF;
  localparam int MAX_REQUEST = MAX_REQUEST_DEF;

  typedef struct packed {
    logic [TARGET_W-1:0] idx;
    logic [STATUS_W-1:0] st;
    logic                was;
    logic                fin;
  } alloc_result_t;

  // Shadow copy of the usage bitmap and the block-count register
  bit [MAP_BITS-1:0]    used_map;
  logic [NUMBLK_W-1:0]  blocks = NUMBLK_W'(NUMBLK_RESET);
  alloc_result_t        owed_results[$];
  alloc_result_t        head;

  int unsigned n_fail   = 0;
  int unsigned n_owed   = 0;
  int unsigned n_cmd    = 0;
  int unsigned n_beat   = 0;
  int unsigned n_grant  = 0;
  int unsigned n_full   = 0;
  int unsigned n_range  = 0;

  assign fail_count  = n_fail;
  assign owed_count  = n_owed;
  assign cmd_count   = n_cmd;
  assign beat_count  = n_beat;
  assign grant_count = n_grant;
  assign full_count  = n_full;
  assign range_count = n_range;

  task automatic report_mismatch(input string msg);
    if (n_fail < 50) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    n_fail++;
  endtask

  task automatic owe(input logic [TARGET_W-1:0] idx, input logic [STATUS_W-1:0] st,
                     input logic was, input logic fin);
    owed_results.push_back({idx, st, was, fin});
  endtask

  // Update the shadow map for one command beat and queue the beats it owes
  task automatic apply_command(input logic [FUNC_W-1:0] f, input logic [TARGET_W-1:0] t,
                               input logic [COUNT_W-1:0] c);
    int unsigned lim;
    int unsigned want;
    int unsigned scan;
    logic        prior;
    lim = (int'(blocks) > MAP_BITS) ? MAP_BITS : int'(blocks);
    if (f == FN_CLEAR) begin
      used_map = '0;
      owe(t, ST_OK, 1'b0, 1'b1);
    end else if (f == FN_ALLOC) begin
      want = (int'(c) > MAX_REQUEST) ? MAX_REQUEST : int'(c);
      scan = 0;
      for (int k = 0; k < want; k++) begin
        // lower indices were seen used already, so resume the scan
        while (scan < lim && used_map[scan]) scan++;
        if (scan < lim) begin
          used_map[scan] = 1'b1;
          owe(TARGET_W'(scan), ST_OK, 1'b0, k + 1 == want);
          n_grant++;
          scan++;
        end else begin
          owe('0, ST_FULL, 1'b0, k + 1 == want);
        end
      end
    end else if (f > FN_QUERY || int'(t) >= lim) begin
      owe(t, ST_RANGE, 1'b0, 1'b1);
    end else begin
      prior = used_map[t];
      if (f == FN_MARK) used_map[t] = 1'b1;
      else if (f == FN_FREE) used_map[t] = 1'b0;
      owe(t, ST_OK, prior, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      used_map = '0;
      blocks = NUMBLK_W'(NUMBLK_RESET);
      owed_results.delete();
    end else begin
      if (result_valid === 1'b1) begin
        n_beat++;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed (block_index %0d, status %0d)",
                                    block_index, status));
        end else begin
          head = owed_results.pop_front();
          if (block_index !== head.idx)
            report_mismatch($sformatf("block_index expected %0d got %0d", head.idx, block_index));
          if (status !== head.st)
            report_mismatch($sformatf("status expected %0d got %0d", head.st, status));
          if (was_used !== head.was)
            report_mismatch($sformatf("was_used expected %0d got %0d", head.was, was_used));
          if (last !== head.fin)
            report_mismatch($sformatf("last expected %0d got %0d", head.fin, last));
          if (head.st == ST_FULL) n_full++;
          if (head.st == ST_RANGE) n_range++;
        end
      end
      if (cfg_we === 1'b1) blocks = cfg_wdata;
      if (start === 1'b1 && busy === 1'b0) begin
        n_cmd++;
        apply_command(func, target_block, request_count);
      end
    end
    n_owed = owed_results.size();
  end

endmodule

/* bench/bitmap_first_fit_block_allocator_tb.sv */
// Stimulus and verdict for the bitmap first-fit block allocator.
// Depends on bffa_pkg, the allocator RTL and bench/bffa_checker.sv.
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_tb;
  import bffa_pkg::*;

  localparam int MAP_BITS = MAP_BITS_DEF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func = FN_QUERY;
  logic [TARGET_W-1:0] target_block = '0;
  logic [COUNT_W-1:0]  request_count = '0;
  logic                cfg_we = 1'b0;
  logic [NUMBLK_W-1:0] cfg_wdata = '0;
  logic                result_valid;
  logic [TARGET_W-1:0] block_index;
  logic [STATUS_W-1:0] status;
  logic                was_used;
  logic                last;

  int unsigned fail_count, owed_count, cmd_count, beat_count;
  int unsigned grant_count, full_count, range_count;

  // usable block count as the stimulus sees it, for shaping targets
  int cur_blocks = MAP_BITS;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bitmap_first_fit_block_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .target_block (target_block),
    .request_count(request_count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .block_index  (block_index),
    .status       (status),
    .was_used     (was_used),
    .last         (last)
  );

  bffa_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .target_block (target_block),
    .request_count(request_count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .block_index  (block_index),
    .status       (status),
    .was_used     (was_used),
    .last         (last),
    .fail_count   (fail_count),
    .owed_count   (owed_count),
    .cmd_count    (cmd_count),
    .beat_count   (beat_count),
    .grant_count  (grant_count),
    .full_count   (full_count),
    .range_count  (range_count)
  );

  // Present one command beat and hold it until the block takes it
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [TARGET_W-1:0] t,
                       input logic [COUNT_W-1:0] c);
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    target_block <= t;
    request_count <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start, with noise on the command fields
  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      func <= FUNC_W'($urandom_range(0, 7));
      target_block <= TARGET_W'($urandom_range(0, MAP_BITS - 1));
      request_count <= COUNT_W'($urandom_range(0, 15));
    end
  endtask

  // Hold off until every owed beat is back and the block is quiet
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (owed_count != 0 || busy) @(negedge clk);
  endtask

  task automatic set_block_count(input logic [NUMBLK_W-1:0] v);
    drain();
    // an allocate of zero blocks owes nothing and never raises busy
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= NUMBLK_W'($urandom_range(0, 16383));
    cur_blocks = (int'(v) > MAP_BITS) ? MAP_BITS : int'(v);
  endtask

  function automatic logic [TARGET_W-1:0] pick_target();
    int unsigned r;
    int          hi;
    r = $urandom_range(0, 9);
    if (cur_blocks == 0 || r < 2) return TARGET_W'($urandom_range(0, MAP_BITS - 1));
    if (r == 9 && cur_blocks < MAP_BITS) return TARGET_W'(cur_blocks);
    // much of the traffic lands where allocations have been handing out blocks
    hi = (r < 6 && cur_blocks > 96) ? 95 : cur_blocks - 1;
    return TARGET_W'($urandom_range(0, hi));
  endfunction

  initial begin
    #4000000;
    $display("Run timed out with %0d result beats still owed", owed_count);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned settings[9];
    int unsigned r;
    int unsigned idle_pct;
    logic [FUNC_W-1:0]  f;
    logic [COUNT_W-1:0] c;

    settings = '{40, 8192, 3, 16383, 100, 0, 8191, 64, 12};
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part, block count at its reset value
    issue(FN_QUERY, 13'd0, 4'd0);
    issue(FN_ALLOC, 13'd0, 4'd1);
    issue(FN_ALLOC, 13'd0, 4'd8);
    issue(FN_ALLOC, 13'd0, 4'd15);
    issue(FN_ALLOC, 13'd0, 4'd0);
    issue(FN_MARK, 13'h1FFF, 4'd0);
    issue(FN_QUERY, 13'h1FFF, 4'd0);
    issue(FN_FREE, 13'h1FFF, 4'd0);
    issue(FN_FREE, 13'h1FFF, 4'd0);
    issue(FN_FREE, 13'd3, 4'd0);
    issue(FN_ALLOC, 13'd0, 4'd2);
    issue(FN_MARK, 13'd0, 4'd0);
    issue(3'd5, 13'h1FFF, 4'd1);
    issue(3'd6, 13'd0, 4'd2);
    issue(3'd7, 13'h0AAA, 4'd3);
    issue(FN_CLEAR, 13'h1555, 4'd7);
    issue(FN_QUERY, 13'd5, 4'd0);
    set_block_count(14'd0);
    issue(FN_ALLOC, 13'd0, 4'd3);
    issue(FN_QUERY, 13'd0, 4'd0);
    issue(FN_MARK, 13'd0, 4'd0);
    set_block_count(14'd1);
    issue(FN_ALLOC, 13'd0, 4'd4);
    issue(FN_QUERY, 13'd1, 4'd0);
    issue(FN_FREE, 13'd0, 4'd0);
    set_block_count(14'h3FFF);
    issue(FN_QUERY, 13'h1FFF, 4'd0);
    issue(FN_ALLOC, 13'd0, 4'd8);

    // Random part: one phase per block-count setting
    foreach (settings[p]) begin
      set_block_count(NUMBLK_W'(settings[p]));
      idle_pct = (p == 2) ? 0 : 35;
      for (int i = 0; i < 16; i++) begin
        if (p == 4 && i == 8) drain();
        if ($urandom_range(0, 99) < idle_pct) idle($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        c = COUNT_W'($urandom_range(0, 15));
        if (r < 47) begin
          f = FN_ALLOC;
          if (r < 3) c = '0;
          else if ($urandom_range(0, 9) != 0) c = COUNT_W'($urandom_range(1, 8));
        end else if (r < 62) begin
          f = FN_MARK;
        end else if (r < 76) begin
          f = FN_FREE;
        end else if (r < 89) begin
          f = FN_QUERY;
        end else if (r < 94) begin
          f = FN_CLEAR;
        end else begin
          f = FUNC_W'($urandom_range(5, 7));
        end
        issue(f, pick_target(), c);
      end
    end

    drain();
    repeat (16) @(negedge clk);
    $display("Covered %0d commands and %0d result beats: %0d blocks granted, %0d full slots",
             cmd_count, beat_count, grant_count, full_count);
    $display("%0d out-of-range answers; block counts 0, 1, 3, 12, 40, 64, 100, 8191, 8192, 16383",
             range_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_ram.sv
hw/rtl/bffa_find.sv
hw/rtl/bitmap_first_fit_block_allocator.sv
bench/bffa_checker.sv
bench/bitmap_first_fit_block_allocator_tb.sv
